[src/circular_deque_assert.svh]
// circular_deque_assert.svh: assertion macros for the deque checker
// expects signals clk and rst_n in the scope where a macro is used
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque check failed");

// next-cycle implication, checked out of reset
`define CDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

[src/cdq_pkg.sv]
// cdq_pkg: types, codes and defaults shared by the circular deque files
// no dependencies
package cdq_pkg;

  // field widths
  localparam int DATA_W = 32;
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;
  localparam int CAP_W  = 5;

  // default store depth and capacity after reset
  localparam int              DEPTH_DEF = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [MODE_W-1:0]        mode_t;
  typedef logic [STAT_W-1:0]        stat_t;
  typedef logic [CAP_W-1:0]         cap_t;

  // request modes
  localparam mode_t MODE_PUSH_FRONT = 3'd0;
  localparam mode_t MODE_PUSH_BACK  = 3'd1;
  localparam mode_t MODE_POP_FRONT  = 3'd2;
  localparam mode_t MODE_POP_BACK   = 3'd3;
  localparam mode_t MODE_PEEK       = 3'd4;

  // result status codes
  localparam stat_t STAT_DONE      = 2'd0;
  localparam stat_t STAT_OVERFLOW  = 2'd1;
  localparam stat_t STAT_UNDERFLOW = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic accept;  // request taken this cycle
    logic rd;      // read both ends of the store
    logic load;    // load the output register
  } cdq_cmd_t;

endpackage

[src/cdq_in_if.sv]
// cdq_in_if: request channel of the circular deque (mode and value)
// depends on cdq_pkg
interface cdq_in_if import cdq_pkg::*; ();
  logic  valid;
  logic  ready;
  mode_t mode;
  data_t value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

[src/cdq_out_if.sv]
// cdq_out_if: result channel of the circular deque
// depends on cdq_pkg
interface cdq_out_if import cdq_pkg::*; ();
  logic  valid;
  logic  ready;
  stat_t status;
  data_t front_value;
  data_t back_value;
  logic  is_empty;
  logic  is_full;

  modport source (output valid, output status, output front_value, output back_value,
                  output is_empty, output is_full, input ready);
  modport sink (input valid, input status, input front_value, input back_value,
                input is_empty, input is_full, output ready);
endinterface

[src/cdq_ctrl.sv]
// cdq_ctrl: request sequencing and output handshake of the circular deque
// depends on cdq_pkg
module cdq_ctrl import cdq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output cdq_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // commands
  always_comb begin
    cmd.accept = (state_r == ST_IDLE) && in_valid;
    cmd.rd     = (state_r == ST_RD);
    cmd.load   = (state_r == ST_WB) && (!out_valid_r || out_ready);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (cmd.load) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid: set on load, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[src/cdq_dp.sv]
// cdq_dp: pointers, slot store and output register of the circular deque
// depends on cdq_pkg; driven by cdq_ctrl commands
module cdq_dp import cdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cdq_cmd_t cmd,
  input  logic     cfg_we,
  input  cap_t     cfg_wdata,
  input  mode_t    in_mode,
  input  data_t    in_value,
  output stat_t    out_status,
  output data_t    out_front_value,
  output data_t    out_back_value,
  output logic     out_is_empty,
  output logic     out_is_full
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [EW-1:0]    ecnt_t;

  // index plus one, wrapping at the capacity
  function automatic idx_t step_up(input idx_t idx, input ecnt_t c);
    ecnt_t n;
    n = ecnt_t'(idx) + ecnt_t'(1);
    return (n >= c) ? '0 : n[IDX_W-1:0];
  endfunction

  // index minus one, wrapping to the top of the capacity
  function automatic idx_t step_down(input idx_t idx, input ecnt_t c);
    ecnt_t m;
    m = c - ecnt_t'(1);
    return (idx == '0 || ecnt_t'(idx) >= c) ? m[IDX_W-1:0] : idx - idx_t'(1);
  endfunction

  data_t mem [DEPTH];

  cap_t  cap_r;
  idx_t  head_r, head_nxt;
  idx_t  tail_r, tail_nxt;
  logic  empty_r, empty_nxt;
  stat_t status_r, status_nxt;
  logic  full_r;
  data_t rd_front_r, rd_back_r;
  stat_t out_status_r;
  data_t out_front_r, out_back_r;
  logic  out_empty_r, out_full_r;

  ecnt_t ecap;
  logic  is_push, is_pop, full_now, wr_en;
  idx_t  wr_addr;

  // effective capacity: zero reads as one, clamped to the store depth
  always_comb begin
    ecap = ecnt_t'(cap_r);
    if (ecap == '0) ecap = ecnt_t'(1);
    if (ecap > ecnt_t'(DEPTH)) ecap = ecnt_t'(DEPTH);
  end

  assign is_push  = (in_mode == MODE_PUSH_FRONT) || (in_mode == MODE_PUSH_BACK);
  assign is_pop   = (in_mode == MODE_POP_FRONT) || (in_mode == MODE_POP_BACK);
  assign full_now = !empty_r && (step_up(tail_r, ecap) == head_r);

  // pointer update and slot write for one request
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    empty_nxt  = empty_r;
    status_nxt = STAT_DONE;
    wr_en      = 1'b0;
    wr_addr    = '0;
    if (is_push) begin
      if (full_now) begin
        status_nxt = STAT_OVERFLOW;
      end else if (empty_r) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        empty_nxt = 1'b0;
        wr_en     = 1'b1;
        wr_addr   = '0;
      end else if (in_mode == MODE_PUSH_FRONT) begin
        head_nxt = step_down(head_r, ecap);
        wr_en    = 1'b1;
        wr_addr  = head_nxt;
      end else begin
        tail_nxt = step_up(tail_r, ecap);
        wr_en    = 1'b1;
        wr_addr  = tail_nxt;
      end
    end else if (is_pop) begin
      if (empty_r) begin
        status_nxt = STAT_UNDERFLOW;
      end else if (head_r == tail_r) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        empty_nxt = 1'b1;
      end else if (in_mode == MODE_POP_FRONT) begin
        head_nxt = step_up(head_r, ecap);
      end else begin
        tail_nxt = step_down(tail_r, ecap);
      end
    end
  end

  // control state: capacity and pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else if (cfg_we) begin
      cap_r   <= cfg_wdata;
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else if (cmd.accept) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  // slot store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) mem[wr_addr] <= in_value;
    if (cmd.rd) begin
      rd_front_r <= mem[head_r];
      rd_back_r  <= mem[tail_r];
    end
  end

  // per-request status and full flag
  always_ff @(posedge clk) begin
    if (cmd.accept) status_r <= status_nxt;
    if (cmd.rd) full_r <= full_now;
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r <= status_r;
      out_front_r  <= empty_r ? '1 : rd_front_r;
      out_back_r   <= empty_r ? '1 : rd_back_r;
      out_empty_r  <= empty_r;
      out_full_r   <= full_r;
    end
  end

  assign out_status      = out_status_r;
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;

endmodule

[src/circular_deque.sv]
// circular_deque: top level of the double-ended queue, controller plus datapath
// depends on cdq_pkg, cdq_in_if, cdq_out_if, cdq_ctrl, cdq_dp
//
// Double-ended queue of signed 32-bit words in a circular store of DEPTH
// slots, wrapping at the capacity register (0 acts as 1, values above DEPTH
// act as DEPTH; writing it empties the deque). Each request pushes or pops
// at either end or only peeks, and gives one result: status, front and back
// words (-1 when empty), empty and full. A request moves through its steps
// in order: on acceptance it moves a pointer and writes the slot, then both
// ends are read through the store's two registered read ports, then the
// result is loaded into the output register. One request is in work at a
// time: a new one is taken only once the last one has loaded its result.
// A new request is taken while a finished result still waits in the output
// register; that request then holds in its load step, and the input stalls,
// until the waiting result is taken.
module circular_deque import cdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  cdq_in_if.sink          in_ch,
  cdq_out_if.source       out_ch,
  input  logic            cfg_we,
  input  cap_t            cfg_wdata
);

  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_mode         (in_ch.mode),
    .in_value        (in_ch.value),
    .out_status      (out_ch.status),
    .out_front_value (out_ch.front_value),
    .out_back_value  (out_ch.back_value),
    .out_is_empty    (out_ch.is_empty),
    .out_is_full     (out_ch.is_full)
  );

endmodule

[src/cdq_chk.sv]
// cdq_chk: port-level checks of the circular deque, bound to the top level
// depends on cdq_pkg and circular_deque_assert.svh
`include "circular_deque_assert.svh"

module cdq_chk import cdq_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input stat_t status,
  input data_t front_value,
  input data_t back_value,
  input logic  is_empty,
  input logic  is_full
);

  // a stalled result holds
  `CDQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(front_value) && $stable(back_value))

  // an empty deque shows all ones at both ends and is never full
  `CDQ_ASSERT_NOW(a_empty_vals, out_valid && is_empty, front_value == '1 && back_value == '1 && !is_full)

  // a refused push leaves the deque full, a refused pop leaves it empty
  `CDQ_ASSERT_NOW(a_overflow_full, out_valid && status == STAT_OVERFLOW, is_full)
  `CDQ_ASSERT_NOW(a_underflow_empty, out_valid && status == STAT_UNDERFLOW, is_empty)

  // one request at a time: no request taken right after one was taken
  `CDQ_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready)

endmodule

bind circular_deque cdq_chk u_cdq_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .front_value (out_ch.front_value),
  .back_value  (out_ch.back_value),
  .is_empty    (out_ch.is_empty),
  .is_full     (out_ch.is_full)
);

[tb/sv/circular_deque_checker.sv]
// circular_deque_checker: watches the request, result and capacity ports of the deque,
// predicts every result and compares it with what the block returns
// depends on cdq_pkg, cdq_in_if, cdq_out_if
module circular_deque_checker import cdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  cdq_in_if    req_mon,
  cdq_out_if   res_mon,
  input  logic cfg_we,
  input  cap_t cfg_wdata,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // one result as the block should report it
  typedef struct packed {
    stat_t status;
    data_t front_value;
    data_t back_value;
    logic  is_empty;
    logic  is_full;
  } deque_view_t;

  // predicted deque contents and pointers
  data_t slot_mem [DEPTH];
  int    head_pos;
  int    tail_pos;
  bit    no_entries;
  cap_t  capacity_reg;

  deque_view_t deque_view_q[$];
  int          errors = 0;

  function automatic int wrap_up(int idx, int lim);
    return (idx + 1 >= lim) ? 0 : idx + 1;
  endfunction

  function automatic int wrap_down(int idx, int lim);
    return (idx == 0 || idx >= lim) ? lim - 1 : idx - 1;
  endfunction

  function automatic bit deque_is_full(int lim);
    return !no_entries && wrap_up(tail_pos, lim) == head_pos;
  endfunction

  function automatic void clear_deque();
    head_pos   = 0;
    tail_pos   = 0;
    no_entries = 1'b1;
  endfunction

  // apply one request to the predicted deque and return the view after it
  function automatic deque_view_t apply_request(mode_t m, data_t v);
    int          lim;
    deque_view_t r;
    lim = (capacity_reg == 0) ? 1 : ((capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg));
    r.status = STAT_DONE;
    case (m)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (deque_is_full(lim)) begin
          r.status = STAT_OVERFLOW;
        end else if (no_entries) begin
          head_pos    = 0;
          tail_pos    = 0;
          no_entries  = 1'b0;
          slot_mem[0] = v;
        end else if (m == MODE_PUSH_FRONT) begin
          head_pos           = wrap_down(head_pos, lim);
          slot_mem[head_pos] = v;
        end else begin
          tail_pos           = wrap_up(tail_pos, lim);
          slot_mem[tail_pos] = v;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (no_entries) begin
          r.status = STAT_UNDERFLOW;
        end else if (head_pos == tail_pos) begin
          clear_deque();
        end else if (m == MODE_POP_FRONT) begin
          head_pos = wrap_up(head_pos, lim);
        end else begin
          tail_pos = wrap_down(tail_pos, lim);
        end
      end
      // peek and the unused codes leave the deque alone
      default: ;
    endcase
    r.front_value = no_entries ? data_t'(-1) : slot_mem[head_pos];
    r.back_value  = no_entries ? data_t'(-1) : slot_mem[tail_pos];
    r.is_empty    = no_entries;
    r.is_full     = deque_is_full(lim);
    return r;
  endfunction

  function automatic void check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want_v, got_v);
      errors++;
    end
  endfunction

  // track config writes, predict on each request, compare on each result
  always @(posedge clk) begin
    deque_view_t want;
    if (!rst_n) begin
      clear_deque();
      capacity_reg = CAP_RESET;
      deque_view_q.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (deque_view_q.size() == 0) begin
          $display("%0t: result with none expected, expected none actual %h %h %h %b %b",
                   $time, res_mon.status, res_mon.front_value, res_mon.back_value,
                   res_mon.is_empty, res_mon.is_full);
          errors++;
        end else begin
          want = deque_view_q.pop_front();
          check_field("status", 32'(want.status), 32'(res_mon.status));
          check_field("front_value", want.front_value, res_mon.front_value);
          check_field("back_value", want.back_value, res_mon.back_value);
          check_field("is_empty", 32'(want.is_empty), 32'(res_mon.is_empty));
          check_field("is_full", 32'(want.is_full), 32'(res_mon.is_full));
        end
      end
      if (cfg_we) begin
        capacity_reg = cfg_wdata;
        clear_deque();
      end
      if (req_mon.valid && req_mon.ready)
        deque_view_q.push_back(apply_request(req_mon.mode, req_mon.value));
    end
    mismatches  <= errors;
    outstanding <= deque_view_q.size();
  end

endmodule

[tb/sv/circular_deque_tb.sv]
// circular_deque_tb: clock, reset and stimulus for the circular deque, verdict at the end
// depends on cdq_pkg, cdq_in_if, cdq_out_if, circular_deque, circular_deque_checker
module circular_deque_tb;
  import cdq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASES      = 10;
  localparam int PHASE_REQS  = 110;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cap_t cfg_wdata;
  int   mismatches;
  int   outstanding;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_off_req = 1'b0;

  cdq_in_if  in_ch ();
  cdq_out_if out_ch ();

  circular_deque DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  circular_deque_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (in_ch),
    .res_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  // offer one request, with random gaps in front of it, and wait for its acceptance
  task automatic send_req(input mode_t m, input data_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= m;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and let every outstanding result drain
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input cap_t c);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic data_t pick_word();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0;
      default: return data_t'($urandom);
    endcase
  endfunction

  // request mix leaning toward pushes or pops by push_pct
  function automatic mode_t pick_mode(int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < 4)
      return mode_t'(MODE_PEEK + $urandom_range(3, 1));
    if (r < 8)
      return MODE_PEEK;
    if (r < 8 + push_pct * 92 / 100)
      return $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
    return $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
  endfunction

  initial begin
    cap_t phase_caps [PHASES];
    int   push_pct;
    phase_caps = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd0, 5'd5, 5'd17, 5'd16, 5'd3, 5'd8};
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode  <= MODE_PEEK;
    in_ch.value <= '0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= CAP_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty deque: underflows, peek and the unused codes
    send_req(MODE_POP_FRONT, 32'h1111_1111);
    send_req(MODE_POP_BACK, 32'h2222_2222);
    send_req(MODE_PEEK, '0);
    send_req(mode_t'(MODE_PEEK + 1), 32'hFFFF_FFFF);
    send_req(mode_t'(MODE_PEEK + 3), '0);
    // extreme words at both ends, then pop down to empty
    send_req(MODE_PUSH_FRONT, 32'h7FFF_FFFF);
    send_req(MODE_PUSH_BACK, 32'h8000_0000);
    send_req(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
    send_req(MODE_PUSH_BACK, 32'h0);
    send_req(mode_t'(MODE_PEEK + 2), 32'h5A5A_5A5A);
    send_req(MODE_POP_FRONT, '0);
    send_req(MODE_POP_BACK, '0);
    send_req(MODE_POP_FRONT, '0);
    send_req(MODE_POP_BACK, '0);
    send_req(MODE_POP_BACK, '0);
    // capacity one: single entry is full, overflow, last pop
    write_capacity(5'd1);
    send_req(MODE_PUSH_BACK, 32'hAAAA_5555);
    send_req(MODE_PUSH_FRONT, 32'h1234_5678);
    send_req(MODE_POP_FRONT, '0);
    send_req(MODE_PUSH_FRONT, 32'h5555_AAAA);
    // capacity zero acts as one; write also empties the deque
    write_capacity(5'd0);
    send_req(MODE_PUSH_BACK, 32'h0000_1234);
    send_req(MODE_PUSH_BACK, 32'h0000_4321);
    send_req(MODE_POP_BACK, '0);
    send_req(MODE_PEEK, '0);

    // random phases, each after a capacity write, under one of three idling patterns
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_caps[p]);
      send_idle_pct <= (p < 3) ? 10 : ((p < 6) ? 84 : 0);
      recv_idle_pct <= (p < 3) ? 84 : ((p < 6) ? 10 : 0);
      // long receiver hold-off while requests keep coming
      if (p == 7)
        hold_off_req <= 1'b1;
      push_pct = 50;
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (n % 16 == 0)
          push_pct = 25 * $urandom_range(3, 1);
        send_req(pick_mode(push_pct), pick_word());
      end
    end

    drain_results();
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
